// File: rtl/core/acs_pkg.sv
package acs_pkg;

    // shared multiplier operand and accumulator widths, sized for fraction bits up to 24
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 28;
    localparam int ACC_W   = 68;
    // width of an lqr effort before smoothing
    localparam int U_W     = 34;

    localparam longint DEG2RAD_Q32 = 74961321;
    localparam int HALF_TURN = 2880;
    localparam int FULL_TURN = 5760;
    localparam int EFFORT_LIM = 16384;

    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef enum logic [2:0] {
        REG_ROLL_REF   = 3'd0,
        REG_PITCH_REF  = 3'd1,
        REG_ANG_PGAIN  = 3'd2,
        REG_ANG_IGAIN  = 3'd3,
        REG_YAW_PGAIN  = 3'd4,
        REG_YAW_IGAIN  = 3'd5,
        REG_YAW_DGAIN  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        SH_ANG  = 2'd0,
        SH_RATE = 2'd1,
        SH_FRAC = 2'd2,
        SH_GAIN = 2'd3
    } t_shift;

    typedef struct packed {
        logic   issue;
        logic   clear;
        logic   neg;
        t_mul_a a;
        t_mul_b b;
    } t_mac_op;

    localparam t_acc MAX32 = t_acc'(64'sd2147483647);
    localparam t_acc MIN32 = t_acc'(-64'sd2147483648);

    // round to nearest, halves away from zero
    function automatic t_acc rshr_acc(t_acc v, int unsigned s);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
        if (s == 0) begin
            return v;
        end
        m = (m + ({{(ACC_W-1){1'b0}}, 1'b1} << (s - 1))) >> s;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(t_acc v);
        if (v > MAX32) begin
            return 32'sh7fffffff;
        end
        if (v < MIN32) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_acc clamp_acc(t_acc v, t_acc lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

// File: rtl/core/acs_if.sv
interface acs_in_if;
    logic               valid;
    logic               ready;
    logic               sample_valid;
    logic signed [13:0] roll_angle;
    logic signed [13:0] pitch_angle;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source (output valid, sample_valid, roll_angle, pitch_angle, rate_x, rate_y,
                    rate_z, input ready);
    modport sink (input valid, sample_valid, roll_angle, pitch_angle, rate_x, rate_y,
                  rate_z, output ready);
endinterface

interface acs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] effort_one;
    logic signed [15:0] effort_two;
    logic signed [15:0] effort_three;
    logic signed [31:0] yaw_effort;

    modport source (output valid, effort_one, effort_two, effort_three, yaw_effort,
                    input ready);
    modport sink (input valid, effort_one, effort_two, effort_three, yaw_effort,
                  output ready);
endinterface

// File: rtl/core/acs_mac.sv
module acs_mac #(
    parameter int FRACTION_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  acs_pkg::t_mac_op i_op,
    input  acs_pkg::t_shift i_sh,
    output acs_pkg::t_acc   o_round
);
    import acs_pkg::*;

    localparam int unsigned SH_ANG_N  = 36 - FRACTION_BITS;
    localparam int unsigned SH_RATE_N = 32 - FRACTION_BITS;
    localparam int unsigned SH_FRAC_N = FRACTION_BITS;

    logic signed [MUL_A_W+MUL_B_W-1:0] r_prod;
    logic r_pvld;
    logic r_clr;
    logic r_neg;
    t_acc r_acc;
    t_acc prod_ext;

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
        r_clr  <= i_op.clear;
        r_neg  <= i_op.neg;
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_op.issue;
        end
    end

    assign prod_ext = t_acc'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= (r_clr ? t_acc'(0) : r_acc) + (r_neg ? -prod_ext : prod_ext);
        end
    end

    always_comb begin
        case (i_sh)
            SH_ANG:  o_round = rshr_acc(r_acc, SH_ANG_N);
            SH_RATE: o_round = rshr_acc(r_acc, SH_RATE_N);
            SH_FRAC: o_round = rshr_acc(r_acc, SH_FRAC_N);
            default: o_round = rshr_acc(r_acc, 8);
        endcase
    end

endmodule

// File: rtl/core/acs_div.sv
module acs_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [acs_pkg::U_W-1:0]    i_num,
    input  logic [acs_pkg::U_W-1:0]    i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [FRACTION_BITS:0]     o_quot
);
    import acs_pkg::*;

    localparam int DW = U_W + FRACTION_BITS + 1;
    localparam int CW = $clog2(FRACTION_BITS + 2);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [FRACTION_BITS:0] r_q;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic take;

    // one quotient bit a cycle, restoring
    assign take = (r_rem >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= (DW'(i_num) << FRACTION_BITS) + DW'(i_den >> 1);
                r_d    <= DW'(i_den) << FRACTION_BITS;
                r_q    <= '0;
                r_cnt  <= CW'(FRACTION_BITS + 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (take) begin
                    r_rem <= r_rem - r_d;
                end
                r_q   <= {r_q[FRACTION_BITS-1:0], take};
                r_d   <= r_d >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/core/attitude_cascade_lqr_yaw_pid_step_core.sv
// channel   | dir | handshake      | word
// i_in      | in  | valid/ready    | sample_valid, roll/pitch angle, gyro rates
// o_out     | out | valid/ready    | three lqr efforts q1.14, yaw effort q16.16
// i_cfg_*   | in  | write enable   | register index, 16-bit data
//
// a valid tick runs through the shared multiply-accumulate unit after it is accepted, and also
// through the serial divider when the efforts need normalizing
// a tick with sample_valid low is taken while idle and gives no word
// the next tick is taken while a finished word waits; the last step holds if it still waits
// reset is synchronous and clears all filter, integrator and smoothing state
module attitude_cascade_lqr_yaw_pid_step_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acs_in_if.sink      i_in,
    acs_out_if.source   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import acs_pkg::*;

    localparam longint ONE     = longint'(1) << FRACTION_BITS;
    localparam longint TENTH   = (ONE + 5) / 10;
    localparam longint FIFTH   = (ONE + 2) / 5;
    localparam longint ANG_LIM = (2 * ONE + 50) / 100;
    localparam longint YAW_LIM = 100 * ONE;
    localparam longint G15     = 3 * ONE / 2;
    localparam longint G2      = 2 * ONE;
    localparam longint OMT     = ONE - TENTH;
    localparam longint OMF     = ONE - FIFTH;
    localparam int ESH = (FRACTION_BITS >= 14) ? FRACTION_BITS - 14 : 14 - FRACTION_BITS;
    localparam int YSH = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 16 - FRACTION_BITS;

    localparam logic [5:0] STEP_NORM  = 6'd31;
    localparam logic [5:0] STEP_DIV0  = 6'd32;
    localparam logic [5:0] STEP_DIV2  = 6'd34;
    localparam logic [5:0] STEP_SMOOTH = 6'd35;
    localparam logic [5:0] STEP_LAST  = 6'd48;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state;
    logic [5:0] r_step;

    logic signed [13:0] r_cfg_roll_ref, r_cfg_pitch_ref;
    logic [15:0] r_cfg_ang_p, r_cfg_ang_i, r_cfg_yaw_p, r_cfg_yaw_i, r_cfg_yaw_d;

    logic signed [13:0] r_roll_in, r_pitch_in;
    logic signed [15:0] r_rate_x, r_rate_y, r_rate_z;

    logic signed [31:0] r_roll, r_pitch, r_wx, r_wy, r_wz;
    logic signed [31:0] r_fx, r_fy, r_fz, r_ix, r_iy, r_yi, r_prev;
    logic signed [31:0] r_sm [3];
    logic signed [31:0] r_ex, r_ey;
    logic signed [U_W-1:0] r_u [3];
    logic [U_W-1:0] r_umax;
    t_acc r_tmp;

    logic r_out_valid;
    logic signed [15:0] r_eff [3];
    logic signed [31:0] r_yaw_out;

    t_mac_op mac_op;
    t_shift sh;
    t_acc rnd;
    logic advance;
    logic in_fire, out_fire, out_free, fin;

    logic div_start, div_busy, div_done;
    logic [U_W-1:0] div_num, div_den, umax_c;
    logic [FRACTION_BITS:0] div_q;
    logic [1:0] div_k;

    logic signed [14:0] dr, dp;
    logic signed [31:0] err;
    t_acc diff10;
    t_acc ref_sum, err_sum;
    logic signed [31:0] ref_sat, e_sat;
    t_acc yaw_sum;
    logic signed [31:0] yaw_sat;
    logic [U_W-1:0] abs_u [3];

    // a full-range difference may need up to three turns removed
    function automatic logic signed [14:0] wrap_angle(logic signed [13:0] a,
                                                       logic signed [13:0] r);
        logic signed [14:0] d;
        d = 15'(a) - 15'(r);
        for (int k = 0; k < 3; k++) begin
            if (d > 15'sd2880) begin
                d = d - 15'(FULL_TURN);
            end else if (d < -15'sd2880) begin
                d = d + 15'(FULL_TURN);
            end
        end
        return d;
    endfunction

    function automatic logic signed [15:0] to_effort(logic signed [31:0] v);
        t_acc x;
        if (FRACTION_BITS >= 14) begin
            x = rshr_acc(t_acc'(v), ESH);
        end else begin
            x = t_acc'(v) <<< ESH;
        end
        return 16'(clamp_acc(x, t_acc'(EFFORT_LIM)));
    endfunction

    function automatic logic signed [31:0] to_yaw(logic signed [31:0] v);
        t_acc x;
        if (FRACTION_BITS >= 16) begin
            x = rshr_acc(t_acc'(v), YSH);
        end else begin
            x = t_acc'(v) <<< YSH;
        end
        return sat32(x);
    endfunction

    function automatic logic signed [31:0] deadband(logic signed [31:0] e);
        if (t_acc'(e) < t_acc'(TENTH) && t_acc'(e) > -t_acc'(TENTH)) begin
            return '0;
        end
        return e;
    endfunction

    assign dr = wrap_angle(r_roll_in, r_cfg_roll_ref);
    assign dp = wrap_angle(r_pitch_in, r_cfg_pitch_ref);
    assign err = sat32(-t_acc'(r_fz));
    assign diff10 = ((t_acc'(err) - t_acc'(r_prev)) <<< 3) + ((t_acc'(err) - t_acc'(r_prev)) <<< 1);

    assign ref_sum = r_tmp + rnd;
    assign ref_sat = sat32(ref_sum);
    assign err_sum = t_acc'((r_step == 6'd21) ? r_fx : r_fy) - t_acc'(ref_sat);
    assign e_sat = deadband(sat32(err_sum));
    assign yaw_sum = r_tmp + rnd;
    assign yaw_sat = to_yaw(sat32(yaw_sum));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_u[k] = r_u[k][U_W-1] ? $unsigned(-r_u[k]) : $unsigned(r_u[k]);
        end
        umax_c = abs_u[0];
        if (abs_u[1] > umax_c) begin
            umax_c = abs_u[1];
        end
        if (abs_u[2] > umax_c) begin
            umax_c = abs_u[2];
        end
    end

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // sequencer: operand selection for each step
    always_comb begin
        mac_op = '0;
        sh = SH_FRAC;
        advance = 1'b1;
        div_start = 1'b0;
        div_k = 2'd0;
        case (r_step)
            6'd0:  mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(dr), t_mul_b'(DEG2RAD_Q32)};
            6'd1:  mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(dp), t_mul_b'(DEG2RAD_Q32)};
            6'd2: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_rate_x), t_mul_b'(DEG2RAD_Q32)};
                sh = SH_ANG;
            end
            6'd3: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_rate_y), t_mul_b'(DEG2RAD_Q32)};
                sh = SH_ANG;
            end
            6'd4: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_rate_z), t_mul_b'(DEG2RAD_Q32)};
                sh = SH_RATE;
            end
            6'd5, 6'd6: sh = SH_RATE;
            6'd7:  mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_wx), t_mul_b'(TENTH)};
            6'd8:  mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_fx), t_mul_b'(OMT)};
            6'd9:  mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_wy), t_mul_b'(TENTH)};
            6'd10: mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_fy), t_mul_b'(OMT)};
            6'd11: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_wz), t_mul_b'(TENTH)};
            6'd12: mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_fz), t_mul_b'(OMT)};
            6'd13: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_roll), t_mul_b'(TENTH)};
            6'd15: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_pitch), t_mul_b'(TENTH)};
            6'd18: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_roll), t_mul_b'(r_cfg_ang_p)};
            6'd19: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_ix), t_mul_b'(r_cfg_ang_i)};
            6'd20: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_pitch), t_mul_b'(r_cfg_ang_p)};
                sh = SH_GAIN;
            end
            6'd21: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_iy), t_mul_b'(r_cfg_ang_i)};
                sh = SH_GAIN;
            end
            6'd22, 6'd23: sh = SH_GAIN;
            6'd24: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_ex), t_mul_b'(G15)};
            6'd25: mac_op = '{1'b1, 1'b0, 1'b1, t_mul_a'(r_ey), t_mul_b'(TENTH)};
            6'd26: mac_op = '{1'b1, 1'b1, 1'b1, t_mul_a'(r_ex), t_mul_b'(G15)};
            6'd27: mac_op = '{1'b1, 1'b0, 1'b1, t_mul_a'(r_ey), t_mul_b'(TENTH)};
            6'd28: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_ey), t_mul_b'(G2)};
            STEP_NORM: div_start = (umax_c > U_W'(ONE));
            6'd32, 6'd33, 6'd34: begin
                advance = div_done;
                div_k = 2'(r_step - STEP_DIV0);
                div_start = div_done && (r_step != STEP_DIV2);
            end
            6'd35: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_u[0]), t_mul_b'(FIFTH)};
            6'd36: mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_sm[0]), t_mul_b'(OMF)};
            6'd37: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_u[1]), t_mul_b'(FIFTH)};
            6'd38: mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_sm[1]), t_mul_b'(OMF)};
            6'd39: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_u[2]), t_mul_b'(FIFTH)};
            6'd40: mac_op = '{1'b1, 1'b0, 1'b0, t_mul_a'(r_sm[2]), t_mul_b'(OMF)};
            6'd41: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(err), t_mul_b'(TENTH)};
            6'd44: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(err), t_mul_b'(r_cfg_yaw_p)};
            6'd45: mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(r_yi), t_mul_b'(r_cfg_yaw_i)};
            6'd46: begin
                mac_op = '{1'b1, 1'b1, 1'b0, t_mul_a'(diff10), t_mul_b'(r_cfg_yaw_d)};
                sh = SH_GAIN;
            end
            6'd47: sh = SH_GAIN;
            STEP_LAST: begin
                sh = SH_GAIN;
                advance = out_free;
            end
            default: ;
        endcase
        if (r_state != S_RUN) begin
            mac_op.issue = 1'b0;
            div_start = 1'b0;
            advance = 1'b0;
        end
    end

    assign fin = (r_state == S_RUN) && (r_step == STEP_LAST) && advance;

    assign div_num = (r_step == STEP_NORM) ? abs_u[0] : abs_u[div_k + 2'd1];
    assign div_den = (r_step == STEP_NORM) ? umax_c : r_umax;

    acs_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_sh    (sh),
        .o_round (rnd)
    );

    acs_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_roll_ref  <= '0;
            r_cfg_pitch_ref <= '0;
            r_cfg_ang_p     <= 16'd1280;
            r_cfg_ang_i     <= 16'd256;
            r_cfg_yaw_p     <= 16'd1280;
            r_cfg_yaw_i     <= 16'd3;
            r_cfg_yaw_d     <= 16'd13;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_ROLL_REF:  r_cfg_roll_ref  <= i_cfg_wdata[13:0];
                REG_PITCH_REF: r_cfg_pitch_ref <= i_cfg_wdata[13:0];
                REG_ANG_PGAIN: r_cfg_ang_p     <= i_cfg_wdata;
                REG_ANG_IGAIN: r_cfg_ang_i     <= i_cfg_wdata;
                REG_YAW_PGAIN: r_cfg_yaw_p     <= i_cfg_wdata;
                REG_YAW_IGAIN: r_cfg_yaw_i     <= i_cfg_wdata;
                REG_YAW_DGAIN: r_cfg_yaw_d     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input capture and control
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_roll_in  <= i_in.roll_angle;
            r_pitch_in <= i_in.pitch_angle;
            r_rate_x   <= i_in.rate_x;
            r_rate_y   <= i_in.rate_y;
            r_rate_z   <= i_in.rate_z;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_in.sample_valid) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    if (fin) begin
                        r_state <= S_IDLE;
                    end else if (advance) begin
                        if (r_step == STEP_NORM && !div_start) begin
                            r_step <= STEP_SMOOTH;
                        end else begin
                            r_step <= r_step + 6'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath register writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && advance) begin
            case (r_step)
                6'd2:  r_roll  <= 32'(rnd);
                6'd3:  r_pitch <= 32'(rnd);
                6'd4:  r_wx    <= sat32(rnd);
                6'd5:  r_wy    <= sat32(rnd);
                6'd6:  r_wz    <= sat32(rnd);
                6'd20, 6'd22: r_tmp <= rnd;
                6'd21: r_ex <= e_sat;
                6'd23: r_ey <= e_sat;
                6'd27: r_u[0] <= U_W'(-rnd);
                6'd29: r_u[1] <= U_W'(-rnd);
                6'd30: r_u[2] <= U_W'(-rnd);
                STEP_NORM: r_umax <= umax_c;
                6'd32, 6'd33, 6'd34: begin
                    r_u[div_k] <= r_u[div_k][U_W-1] ? -$signed(U_W'(div_q))
                                                    : $signed(U_W'(div_q));
                end
                6'd46: r_tmp <= rnd;
                6'd47: r_tmp <= r_tmp + rnd;
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx   <= '0;
            r_fy   <= '0;
            r_fz   <= '0;
            r_ix   <= '0;
            r_iy   <= '0;
            r_yi   <= '0;
            r_prev <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sm[k] <= '0;
            end
        end else if (r_state == S_RUN && advance) begin
            case (r_step)
                6'd10: r_fx <= sat32(rnd);
                6'd12: r_fy <= sat32(rnd);
                6'd14: r_fz <= sat32(rnd);
                6'd15: r_ix <= 32'(clamp_acc(t_acc'(r_ix) + rnd, t_acc'(ANG_LIM)));
                6'd17: r_iy <= 32'(clamp_acc(t_acc'(r_iy) + rnd, t_acc'(ANG_LIM)));
                6'd38: r_sm[0] <= sat32(rnd);
                6'd40: r_sm[1] <= sat32(rnd);
                6'd42: r_sm[2] <= sat32(rnd);
                6'd43: r_yi <= 32'(clamp_acc(t_acc'(r_yi) + rnd, t_acc'(YAW_LIM)));
                STEP_LAST: r_prev <= err;
                default: ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (fin) begin
            for (int k = 0; k < 3; k++) begin
                r_eff[k] <= to_effort(r_sm[k]);
            end
            r_yaw_out <= yaw_sat;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.effort_one   = r_eff[0];
    assign o_out.effort_two   = r_eff[1];
    assign o_out.effort_three = r_eff[2];
    assign o_out.yaw_effort   = r_yaw_out;

    a_ang_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (t_acc'(r_ix) <= t_acc'(ANG_LIM) && t_acc'(r_ix) >= -t_acc'(ANG_LIM)
         && t_acc'(r_iy) <= t_acc'(ANG_LIM) && t_acc'(r_iy) >= -t_acc'(ANG_LIM)))
        else $error("angle integrator out of range");

    a_yaw_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (t_acc'(r_yi) <= t_acc'(YAW_LIM) && t_acc'(r_yi) >= -t_acc'(YAW_LIM)))
        else $error("yaw integrator out of range");

    a_div_in_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_RUN
                      && (r_step == 6'd32 || r_step == 6'd33 || r_step == 6'd34)))
        else $error("divider busy outside normalization");

    a_fin_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (o_out.valid && r_state == S_IDLE))
        else $error("finished tick gave no word");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import acs_pkg::*;

    localparam int FB = 16;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam longint TENTH_Q = (ONE_Q + 5) / 10;
    localparam longint FIFTH_Q = (ONE_Q + 2) / 5;
    localparam longint ANG_LIM_Q = (2 * ONE_Q + 50) / 100;
    localparam longint YAW_LIM_Q = 100 * ONE_Q;
    localparam longint D2R_Q32 = 74961321;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic               sample_valid;
        logic signed [13:0] roll_angle;
        logic signed [13:0] pitch_angle;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] effort_one;
        logic signed [15:0] effort_two;
        logic signed [15:0] effort_three;
        logic signed [31:0] yaw_effort;
    } t_effort;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [2:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    acs_in_if i_in ();
    acs_out_if o_out ();

    attitude_cascade_lqr_yaw_pid_step_core #(.FRACTION_BITS(FB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in.sink), .o_out(o_out.source),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    longint gain [7];
    longint filt_x, filt_y, filt_z, roll_int, pitch_int, yaw_int, prev_yaw_err;
    longint smooth [3];

    t_tick tick_queue [$];
    t_effort effort_queue [$];
    int n_mismatch = 0;
    int n_words = 0;
    int n_ticks = 0;
    int n_norm = 0;
    bit drain_hold = 1'b0;
    bit stim_done = 1'b0;
    int watchdog = 0;

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = v < 0 ? -v : v;
        if (s > 0) m = (m + (64'sd1 << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint wrap_rad(longint a, longint r);
        longint d;
        d = a - r;
        while (d > HALF_TURN) d -= FULL_TURN;
        while (d < -HALF_TURN) d += FULL_TURN;
        return round_shift(d * D2R_Q32, 36 - FB);
    endfunction

    function automatic longint smooth_rate(longint raw, longint last);
        longint w;
        w = sat_word(round_shift(raw * D2R_Q32, 32 - FB));
        return sat_word(round_shift(w * TENTH_Q + last * (ONE_Q - TENTH_Q), FB));
    endfunction

    function automatic longint outer_loop(longint w, longint ang, ref longint integ);
        longint i, rref, e;
        i = clip(integ + round_shift(ang * TENTH_Q, FB), ANG_LIM_Q);
        integ = i;
        rref = sat_word(round_shift(gain[REG_ANG_PGAIN] * ang, 8)
                        + round_shift(gain[REG_ANG_IGAIN] * i, 8));
        e = sat_word(w - rref);
        if (mag(e) < TENTH_Q) e = 0;
        return e;
    endfunction

    function automatic t_effort control_tick(t_tick t);
        longint roll, pitch, ex, ey, umax, err, yi, yaw, s, m;
        longint u [3];
        t_effort r;
        roll = wrap_rad(longint'(t.roll_angle), gain[REG_ROLL_REF]);
        pitch = wrap_rad(longint'(t.pitch_angle), gain[REG_PITCH_REF]);
        filt_x = smooth_rate(longint'(t.rate_x), filt_x);
        filt_y = smooth_rate(longint'(t.rate_y), filt_y);
        filt_z = smooth_rate(longint'(t.rate_z), filt_z);
        ex = outer_loop(filt_x, roll, roll_int);
        ey = outer_loop(filt_y, pitch, pitch_int);
        u[0] = -round_shift((3 * ONE_Q / 2) * ex - TENTH_Q * ey, FB);
        u[1] = -round_shift(-(3 * ONE_Q / 2) * ex - TENTH_Q * ey, FB);
        u[2] = -round_shift(2 * ONE_Q * ey, FB);
        umax = mag(u[0]);
        if (mag(u[1]) > umax) umax = mag(u[1]);
        if (mag(u[2]) > umax) umax = mag(u[2]);
        if (umax > ONE_Q) begin
            n_norm++;
            for (int k = 0; k < 3; k++) begin
                m = (mag(u[k]) * ONE_Q + umax / 2) / umax;
                u[k] = u[k] < 0 ? -m : m;
            end
        end
        for (int k = 0; k < 3; k++) begin
            s = round_shift(u[k] * FIFTH_Q + smooth[k] * (ONE_Q - FIFTH_Q), FB);
            smooth[k] = sat_word(s);
        end
        r.effort_one = 16'(clip(round_shift(smooth[0], FB - 14), EFFORT_LIM));
        r.effort_two = 16'(clip(round_shift(smooth[1], FB - 14), EFFORT_LIM));
        r.effort_three = 16'(clip(round_shift(smooth[2], FB - 14), EFFORT_LIM));
        err = sat_word(-filt_z);
        yi = clip(yaw_int + round_shift(err * TENTH_Q, FB), YAW_LIM_Q);
        yaw_int = yi;
        yaw = round_shift(gain[REG_YAW_PGAIN] * err, 8) + round_shift(gain[REG_YAW_IGAIN] * yi, 8)
            + round_shift(gain[REG_YAW_DGAIN] * ((err - prev_yaw_err) * 10), 8);
        prev_yaw_err = err;
        r.yaw_effort = 32'(sat_word(sat_word(yaw)));
        return r;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in.valid <= 1'b0;
        end else if (i_in.valid && !i_in.ready) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_in.valid <= 1'b0;
        end else if (tick_queue.size() > 0 && !drain_hold) begin
            i_in.valid <= 1'b1;
            {i_in.sample_valid, i_in.roll_angle, i_in.pitch_angle, i_in.rate_x, i_in.rate_y,
             i_in.rate_z} <= tick_queue.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
            i_in.valid <= 1'b0;
        end
    end

    // predict on acceptance, and watch for progress
    always @(posedge i_clk) begin
        if (i_rst_n && i_in.valid && i_in.ready) begin
            t_tick t;
            t = {i_in.sample_valid, i_in.roll_angle, i_in.pitch_angle, i_in.rate_x,
                 i_in.rate_y, i_in.rate_z};
            n_ticks++;
            if (t.sample_valid) effort_queue.push_back(control_tick(t));
        end
        if ((i_in.valid && i_in.ready) || (o_out.valid && o_out.ready)) watchdog <= 0;
        else watchdog <= watchdog + 1;
    end

    // monitor
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.ready <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                t_effort got, want;
                got = {o_out.effort_one, o_out.effort_two, o_out.effort_three,
                       o_out.yaw_effort};
                n_words++;
                if (effort_queue.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected word %h", got);
                end else begin
                    want = effort_queue.pop_front();
                    if (got.effort_one !== want.effort_one
                        || got.effort_two !== want.effort_two
                        || got.effort_three !== want.effort_three
                        || got.yaw_effort !== want.yaw_effort) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("word %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     n_words, want.effort_one, want.effort_two,
                                     want.effort_three, want.yaw_effort, got.effort_one,
                                     got.effort_two, got.effort_three, got.yaw_effort);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                o_out.ready <= 1'b0;
            end else if (o_out.valid && o_out.ready) begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                o_out.ready <= 1'b0;
            end else begin
                o_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_idle();
        while (tick_queue.size() > 0 || i_in.valid || effort_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx <= REG_PITCH_REF) gain[idx] = longint'($signed(v[13:0]));
        else gain[idx] = longint'(v);
        @(posedge i_clk);
    endtask

    function automatic logic signed [13:0] rand_angle(int mode);
        case (mode)
            0: return 14'($urandom_range(0, 11520) - 5760);
            1: return 14'($urandom_range(0, 200) - 100);
            default: return 14'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_rate();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40) - 20);
            2: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom_range(0, 6000) - 3000);
        endcase
    endfunction

    task automatic push_random(int count);
        t_tick t;
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 2);
            t.sample_valid = ($urandom_range(0, 9) != 0);
            t.roll_angle = rand_angle(mode);
            t.pitch_angle = rand_angle(mode);
            t.rate_x = rand_rate();
            t.rate_y = rand_rate();
            t.rate_z = rand_rate();
            tick_queue.push_back(t);
        end
    endtask

    initial begin
        t_tick t;
        gain = '{0, 0, 1280, 256, 1280, 3, 13};
        filt_x = 0; filt_y = 0; filt_z = 0;
        roll_int = 0; pitch_int = 0; yaw_int = 0; prev_yaw_err = 0;
        smooth = '{0, 0, 0};
        i_in.valid = 1'b0;
        {i_in.sample_valid, i_in.roll_angle, i_in.pitch_angle, i_in.rate_x, i_in.rate_y,
         i_in.rate_z} = '0;
        o_out.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero, skipped ticks, deadband edges
        t = '{1'b1, 14'sd0, 14'sd0, 16'sd0, 16'sd0, 16'sd0};
        tick_queue.push_back(t);
        t = '{1'b0, 14'sd5760, -14'sd5760, 16'sh7fff, 16'sh8000, 16'sd100};
        tick_queue.push_back(t);
        t = '{1'b1, 14'sd5760, -14'sd5760, 16'sh7fff, 16'sh8000, 16'sh7fff};
        tick_queue.push_back(t);
        t = '{1'b1, -14'sd5760, 14'sd5760, 16'sh8000, 16'sh7fff, 16'sh8000};
        tick_queue.push_back(t);
        t = '{1'b1, 14'sh1fff, 14'sh2000, 16'shffff, 16'sh0001, 16'sh0000};
        tick_queue.push_back(t);
        t = '{1'b1, 14'sd2880, -14'sd2880, 16'sd6, 16'sd5, 16'sd6};
        tick_queue.push_back(t);
        t = '{1'b1, 14'sd2881, -14'sd2881, -16'sd6, -16'sd5, 16'sd0};
        tick_queue.push_back(t);
        t = '{1'b1, 14'sd1, -14'sd1, 16'sd57, -16'sd57, 16'sd1};
        tick_queue.push_back(t);
        t = '{1'b0, 14'sh1555, 14'sh2aaa, 16'sh5555, 16'shaaaa, 16'sh5555};
        tick_queue.push_back(t);
        for (int k = 0; k < 12; k++) begin
            t = '{1'b1, 14'sd0, 14'sd0, 16'sd20000, -16'sd20000, -16'sd30000};
            tick_queue.push_back(t);
        end
        wait_idle();

        // sweep settings, extremes included, with random traffic between
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_ROLL_REF, 16'(-5760));
                    write_reg(REG_PITCH_REF, 16'd5760);
                end
                1: begin
                    write_reg(REG_ANG_PGAIN, 16'hffff);
                    write_reg(REG_ANG_IGAIN, 16'hffff);
                    write_reg(REG_YAW_PGAIN, 16'hffff);
                    write_reg(REG_YAW_IGAIN, 16'hffff);
                    write_reg(REG_YAW_DGAIN, 16'hffff);
                end
                2: begin
                    write_reg(REG_ANG_PGAIN, 16'd0);
                    write_reg(REG_ANG_IGAIN, 16'd0);
                    write_reg(REG_YAW_PGAIN, 16'd0);
                    write_reg(REG_YAW_IGAIN, 16'd0);
                    write_reg(REG_YAW_DGAIN, 16'd0);
                    write_reg(REG_ROLL_REF, 16'd5760);
                    write_reg(REG_PITCH_REF, 16'(-5760));
                end
                3: begin
                    write_reg(REG_ROLL_REF, 16'd0);
                    write_reg(REG_PITCH_REF, 16'd0);
                    write_reg(REG_ANG_PGAIN, 16'd1280);
                    write_reg(REG_ANG_IGAIN, 16'd256);
                    write_reg(REG_YAW_PGAIN, 16'd1280);
                    write_reg(REG_YAW_IGAIN, 16'd3);
                    write_reg(REG_YAW_DGAIN, 16'd13);
                end
                default: begin
                    write_reg(REG_ROLL_REF, 16'($urandom_range(0, 11520) - 5760));
                    write_reg(REG_PITCH_REF, 16'($urandom_range(0, 11520) - 5760));
                    write_reg(REG_ANG_PGAIN, 16'($urandom));
                    write_reg(REG_ANG_IGAIN, 16'($urandom_range(0, 4096)));
                    write_reg(REG_YAW_PGAIN, 16'($urandom));
                    write_reg(REG_YAW_IGAIN, 16'($urandom_range(0, 512)));
                    write_reg(REG_YAW_DGAIN, 16'($urandom));
                end
            endcase
            push_random(100);
            // hold the sender until the pipeline has fully drained
            while (tick_queue.size() > 50) @(posedge i_clk);
            drain_hold = 1'b1;
            @(posedge i_clk);
            while (i_in.valid || effort_queue.size() > 0) @(posedge i_clk);
            drain_hold = 1'b0;
            push_random(100);
            wait_idle();
        end
        stim_done = 1'b1;

        $display("%0d ticks sent, %0d effort words checked, %0d needed normalizing",
                 n_ticks, n_words, n_norm);
        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: attitude_cascade_lqr_yaw_pid_step_core.f
rtl/core/acs_pkg.sv
rtl/core/acs_if.sv
rtl/core/acs_mac.sv
rtl/core/acs_div.sv
rtl/core/attitude_cascade_lqr_yaw_pid_step_core.sv
sim/tb_top.sv
